// ----- rtl/tps_pkg.sv -----
// ============================================================================
// tps_pkg: shared definitions of the TLB purge sequencer
// Holds the sizing constants, the purge kind and register index codes, the
// controller state type and the command and status groups between the
// controller and the datapath.
// ============================================================================
package tps_pkg;

    localparam int ADDR_W        = 64;
    localparam int MAX_RUN       = 64;
    localparam int MAX_PAGE_LOG2 = 28;
    localparam int MIN_PAGE_LOG2 = 12;
    localparam int RUN_CNT_W     = $clog2(MAX_RUN);
    localparam int LOG2_W        = 5;
    localparam int COUNT_W       = 4;
    localparam int STRIDE_W      = 32;
    localparam int CFG_IDX_W     = 3;

    // Rounding added to the range length before the size is taken.
    localparam logic [ADDR_W-1:0] SIZE_ROUND = 64'h0000_0000_0000_0fff;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_RANGE = 2'd0;
    localparam t_kind KIND_ENTRY = 2'd1;
    localparam t_kind KIND_DROP  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PURGE_BASE   = 3'd0;
    localparam t_cfg_idx CFG_COUNT_OUTER  = 3'd1;
    localparam t_cfg_idx CFG_COUNT_INNER  = 3'd2;
    localparam t_cfg_idx CFG_STRIDE_OUTER = 3'd3;
    localparam t_cfg_idx CFG_STRIDE_INNER = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIZE,
        S_ALIGN,
        S_RANGE,
        S_ALL
    } t_state;

    typedef struct packed {
        logic load_range;
        logic load_all;
        logic emit_drop;
        logic calc_size;
        logic calc_align;
        logic step_range;
        logic step_all;
    } t_dp_cmd;

    typedef struct packed {
        logic range_done;
        logic all_last;
        logic run_full;
        logic counts_zero;
    } t_dp_status;

endpackage

// ----- rtl/tlb_purge_sequencer_unit.sv -----
// ============================================================================
// tlb_purge_sequencer_unit: TLB flush request to purge command sequencer
// Turns one flush request into a run of purge requests, one result a cycle while the walk runs.
// ============================================================================
//
// A request is taken at a rising edge with start high and busy low. During a
// walk, results come out one per cycle on the o_ ports, each marked by
// o_strobe for exactly one cycle; the receiver cannot stall them, so it must
// take every result in the cycle it appears. A range request for the active
// address space first runs its setup steps (take and length sum, page size
// rounding, start alignment) and then one purge per cycle, holding busy
// through the rounding, the alignment and the walk; its last result appears
// in the first cycle with busy low, while the next request may already be
// taken. Each purge step uses the walk address adder and its compare against
// the range end. A range request for an inactive space gives its single
// context-drop result in the cycle after it is taken and never raises busy.
// A flush-all request gives one purge per cycle, count_outer times
// count_inner purges, and gives nothing at all when either count is zero.
// Every run is cut at 64 purges, the final one then carrying o_overflow.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data, and
// should only be written while the block is idle.
//
module tlb_purge_sequencer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [tps_pkg::ADDR_W-1:0]        i_range_start,
    input  logic [tps_pkg::ADDR_W-1:0]        i_range_end,
    input  logic                              i_is_active_space,
    input  logic                              i_cfg_we,
    input  tps_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [tps_pkg::ADDR_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output tps_pkg::t_kind                    o_purge_kind,
    output logic [tps_pkg::ADDR_W-1:0]        o_purge_addr,
    output logic [tps_pkg::LOG2_W-1:0]        o_page_size_log2,
    output logic                              o_overflow,
    output logic                              o_last
);
    import tps_pkg::*;

    // Commands from the controller and status back from the datapath.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tps_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_cmd             (i_cmd),
        .i_is_active_space (i_is_active_space),
        .i_status          (dp_status),
        .o_cmd             (dp_cmd),
        .o_busy            (busy)
    );

    // The datapath owns the configuration registers and the result
    // registers, so a result is always a registered output.
    tps_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_range_start    (i_range_start),
        .i_range_end      (i_range_end),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_status         (dp_status),
        .o_strobe         (o_strobe),
        .o_purge_kind     (o_purge_kind),
        .o_purge_addr     (o_purge_addr),
        .o_page_size_log2 (o_page_size_log2),
        .o_overflow       (o_overflow),
        .o_last           (o_last)
    );

endmodule

// ----- rtl/tps_ctrl.sv -----
// ============================================================================
// tps_ctrl: sequencing controller of the TLB purge sequencer
// Takes each request, steps the datapath through sizing and alignment for a
// range request and runs the purge walk until the datapath reports the end of the run.
// ============================================================================
module tps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_cmd,
    input  logic                i_is_active_space,
    input  tps_pkg::t_dp_status i_status,
    output tps_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);
    import tps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_cmd) begin
                        if (i_is_active_space) begin
                            o_cmd.load_range = 1'b1;
                            n_state          = S_SIZE;
                        end else begin
                            o_cmd.emit_drop = 1'b1;
                        end
                    end else if (!i_status.counts_zero) begin
                        o_cmd.load_all = 1'b1;
                        n_state        = S_ALL;
                    end
                end
            end
            S_SIZE: begin
                o_cmd.calc_size = 1'b1;
                n_state         = S_ALIGN;
            end
            S_ALIGN: begin
                o_cmd.calc_align = 1'b1;
                n_state          = S_RANGE;
            end
            S_RANGE: begin
                o_cmd.step_range = 1'b1;
                if (i_status.range_done || i_status.run_full) begin
                    n_state = S_IDLE;
                end
            end
            S_ALL: begin
                o_cmd.step_all = 1'b1;
                if (i_status.all_last || i_status.run_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/tps_dp.sv -----
// ============================================================================
// tps_dp: datapath of the TLB purge sequencer
// Holds the configuration registers, the size and alignment logic, the walk
// address and counters, and the registered result ports.
// ============================================================================
module tps_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tps_pkg::t_dp_cmd                  i_cmd,
    input  logic [tps_pkg::ADDR_W-1:0]        i_range_start,
    input  logic [tps_pkg::ADDR_W-1:0]        i_range_end,
    input  logic                              i_cfg_we,
    input  tps_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [tps_pkg::ADDR_W-1:0]        i_cfg_data,
    output tps_pkg::t_dp_status               o_status,
    output logic                              o_strobe,
    output tps_pkg::t_kind                    o_purge_kind,
    output logic [tps_pkg::ADDR_W-1:0]        o_purge_addr,
    output logic [tps_pkg::LOG2_W-1:0]        o_page_size_log2,
    output logic                              o_overflow,
    output logic                              o_last
);
    import tps_pkg::*;

    // Configuration registers.
    logic [ADDR_W-1:0]   r_purge_base;
    logic [COUNT_W-1:0]  r_count_outer;
    logic [COUNT_W-1:0]  r_count_inner;
    logic [STRIDE_W-1:0] r_stride_outer;
    logic [STRIDE_W-1:0] r_stride_inner;

    // Walk state.
    logic [ADDR_W-1:0]   r_start;
    logic [ADDR_W-1:0]   r_end;
    logic [ADDR_W-1:0]   r_sum;
    logic [LOG2_W-1:0]   r_size_log2;
    logic [ADDR_W-1:0]   r_step;
    logic [ADDR_W-1:0]   r_addr;
    logic [STRIDE_W:0]   r_stride_wrap;
    logic [RUN_CNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0]  r_outer;
    logic [COUNT_W-1:0]  r_inner;

    // Result registers.
    logic                r_strobe;
    t_kind               r_kind;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [LOG2_W-1:0]   r_out_log2;
    logic                r_out_ovf;
    logic                r_out_last;

    logic [LOG2_W-1:0]   n_size_log2;
    logic [LOG2_W-1:0]   v_lead;
    logic                v_high;
    logic [ADDR_W-1:0]   v_step;
    logic [ADDR_W-1:0]   v_range_next;
    logic [ADDR_W-1:0]   v_all_inc;
    logic                v_inner_last;
    logic                v_outer_last;
    logic                v_range_done;
    logic                v_all_last;
    logic                v_run_full;

    // Purge size: position of the leading one, then rounding to a supported
    // page size. Anything above the largest page clamps to it.
    always_comb begin
        v_lead = '0;
        for (int i = 0; i <= MAX_PAGE_LOG2; i++) begin
            if (r_sum[i]) begin
                v_lead = LOG2_W'(i);
            end
        end
        v_high = |r_sum[ADDR_W-1:MAX_PAGE_LOG2+1];
        priority if (v_high) begin
            n_size_log2 = LOG2_W'(MAX_PAGE_LOG2);
        end else if (v_lead < LOG2_W'(MIN_PAGE_LOG2)) begin
            n_size_log2 = LOG2_W'(MIN_PAGE_LOG2);
        end else if ((v_lead <= LOG2_W'(MIN_PAGE_LOG2 + 2)) ||
                     (v_lead == LOG2_W'(MAX_PAGE_LOG2)) || !v_lead[0]) begin
            n_size_log2 = v_lead;
        end else begin
            n_size_log2 = v_lead + LOG2_W'(1);
        end
    end

    assign v_step       = {{(ADDR_W-1){1'b0}}, 1'b1} << r_size_log2;
    assign v_range_next = r_addr + r_step;
    assign v_range_done = !(v_range_next < r_end);
    assign v_inner_last = (r_inner == (r_count_inner - COUNT_W'(1)));
    assign v_outer_last = (r_outer == (r_count_outer - COUNT_W'(1)));
    assign v_all_last   = v_inner_last && v_outer_last;
    assign v_run_full   = (r_cnt == RUN_CNT_W'(MAX_RUN - 1));
    assign v_all_inc    = v_inner_last ? {{(ADDR_W-STRIDE_W-1){1'b0}}, r_stride_wrap}
                                       : {{(ADDR_W-STRIDE_W){1'b0}}, r_stride_inner};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_purge_base   <= '0;
            r_count_outer  <= COUNT_W'(1);
            r_count_inner  <= COUNT_W'(1);
            r_stride_outer <= '0;
            r_stride_inner <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PURGE_BASE:   r_purge_base   <= i_cfg_data;
                CFG_COUNT_OUTER:  r_count_outer  <= i_cfg_data[COUNT_W-1:0];
                CFG_COUNT_INNER:  r_count_inner  <= i_cfg_data[COUNT_W-1:0];
                CFG_STRIDE_OUTER: r_stride_outer <= i_cfg_data[STRIDE_W-1:0];
                CFG_STRIDE_INNER: r_stride_inner <= i_cfg_data[STRIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_range) begin
            r_start <= i_range_start;
            r_end   <= i_range_end;
            r_sum   <= i_range_end - i_range_start + SIZE_ROUND;
            r_cnt   <= '0;
        end
        if (i_cmd.load_all) begin
            r_addr        <= r_purge_base;
            r_stride_wrap <= {1'b0, r_stride_inner} + {1'b0, r_stride_outer};
            r_outer       <= '0;
            r_inner       <= '0;
            r_cnt         <= '0;
        end
        if (i_cmd.calc_size) begin
            r_size_log2 <= n_size_log2;
        end
        if (i_cmd.calc_align) begin
            r_step <= v_step;
            r_addr <= r_start & ~(v_step - {{(ADDR_W-1){1'b0}}, 1'b1});
        end
        if (i_cmd.step_range) begin
            r_addr <= v_range_next;
            r_cnt  <= r_cnt + RUN_CNT_W'(1);
        end
        if (i_cmd.step_all) begin
            r_addr <= r_addr + v_all_inc;
            r_cnt  <= r_cnt + RUN_CNT_W'(1);
            if (v_inner_last) begin
                r_inner <= '0;
                r_outer <= r_outer + COUNT_W'(1);
            end else begin
                r_inner <= r_inner + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_drop | i_cmd.step_range | i_cmd.step_all;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_drop) begin
            r_kind     <= KIND_DROP;
            r_out_addr <= '0;
            r_out_log2 <= LOG2_W'(MIN_PAGE_LOG2);
            r_out_ovf  <= 1'b0;
            r_out_last <= 1'b1;
        end
        if (i_cmd.step_range) begin
            r_kind     <= KIND_RANGE;
            r_out_addr <= r_addr;
            r_out_log2 <= r_size_log2;
            r_out_ovf  <= v_run_full && !v_range_done;
            r_out_last <= v_run_full || v_range_done;
        end
        if (i_cmd.step_all) begin
            r_kind     <= KIND_ENTRY;
            r_out_addr <= r_addr;
            r_out_log2 <= LOG2_W'(MIN_PAGE_LOG2);
            r_out_ovf  <= v_run_full && !v_all_last;
            r_out_last <= v_run_full || v_all_last;
        end
    end

    assign o_status.range_done  = v_range_done;
    assign o_status.all_last    = v_all_last;
    assign o_status.run_full    = v_run_full;
    assign o_status.counts_zero = (r_count_outer == '0) || (r_count_inner == '0);

    assign o_strobe         = r_strobe;
    assign o_purge_kind     = r_kind;
    assign o_purge_addr     = r_out_addr;
    assign o_page_size_log2 = r_out_log2;
    assign o_overflow       = r_out_ovf;
    assign o_last           = r_out_last;

endmodule
